// ===== rtl/adt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_pkg: shared types and constants
// Word formats, controller states and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package adt_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    localparam int CNT_BITS  = 16;
    localparam int NORM_BITS = 2 * WORD_BITS;
    localparam int NTM_BITS  = NORM_BITS - FRAC_BITS + 1;
    localparam int S_BITS    = 52;
    localparam int NEW_BITS  = 52;
    localparam int MA_BITS   = 52;
    localparam int MB_BITS   = 48;
    localparam int CHUNK     = 16;
    localparam int PROD_BITS = MA_BITS + MB_BITS;
    localparam int QUO_BITS  = FRAC_BITS + 1;

    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LAMBDA   = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER = 1'b1;

    localparam logic signed [WORD_BITS-1:0] LAMBDA_RESET   = WORD_BITS'(64'd1 << FRAC_BITS);
    localparam logic [CNT_BITS-1:0]         MAX_ITER_RESET = CNT_BITS'(500);

    localparam logic signed [S_BITS-1:0] ONE_S = S_BITS'(64'd1 << FRAC_BITS);
    localparam logic [NORM_BITS-1:0] NORM_TEN    = NORM_BITS'(10) << (2 * FRAC_BITS);
    localparam logic [NORM_BITS-1:0] NORM_TWENTY = NORM_BITS'(20) << (2 * FRAC_BITS);

    typedef enum logic [4:0] {
        ST_IDLE, ST_C_SR, ST_C_SR_W, ST_C_SI, ST_C_SI_W, ST_C_NC,
        ST_I_LIM, ST_I_SR, ST_I_SR_W, ST_I_SI, ST_I_SI_W, ST_I_TEST,
        ST_I_ZERO, ST_I_ARAI, ST_I_ARAI_W, ST_I_DIV, ST_I_DIV_W,
        ST_I_LAM, ST_I_LAM_W, ST_I_SUR, ST_I_SUR_W, ST_I_SUI, ST_I_SUI_W,
        ST_I_COMMIT, ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        MS_SR, MS_SI, MS_ARAI, MS_LAM, MS_SUR, MS_SUI
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     latch_nc;
        logic     mul_go;
        t_mul_sel mul_sel;
        logic     div_go;
        logic     set_zero;
        logic     commit;
        logic     finish;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic lim;
        logic esc;
        logic nzero;
        logic ovf;
    } t_dp_sts;

endpackage

// ===== rtl/adt_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_mul: sequential magnitude multiplier
// Multiplies two unsigned operands one 16-bit slice of the second per cycle.
// ----------------------------------------------------------------------------
module adt_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_go,
    input  logic [adt_pkg::MA_BITS-1:0]      i_a,
    input  logic [adt_pkg::MB_BITS-1:0]      i_b,
    output logic                             o_done,
    output logic [adt_pkg::PROD_BITS-1:0]    o_prod
);
    import adt_pkg::*;

    localparam int PP_BITS = MA_BITS + CHUNK;

    logic                 r_busy;
    logic                 r_done;
    logic [1:0]           r_k;
    logic [MA_BITS-1:0]   r_a;
    logic [MB_BITS-1:0]   r_b;
    logic [PROD_BITS-1:0] r_acc;
    logic [PP_BITS-1:0]   w_pp;
    logic [PROD_BITS-1:0] w_sh;

    assign w_pp = r_a * r_b[CHUNK-1:0];

    always_comb begin
        case (r_k)
            2'd0:    w_sh = PROD_BITS'(w_pp);
            2'd1:    w_sh = PROD_BITS'(w_pp) << CHUNK;
            2'd2:    w_sh = PROD_BITS'(w_pp) << (2 * CHUNK);
            default: w_sh = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (r_busy) begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_sh;
            r_b   <= r_b >> CHUNK;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/adt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_div: restoring fraction divider
// Gives floor(num * 2^FRAC_BITS / den) for num <= den, one bit per cycle.
// ----------------------------------------------------------------------------
module adt_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_go,
    input  logic [adt_pkg::NORM_BITS-1:0]   i_num,
    input  logic [adt_pkg::NORM_BITS-1:0]   i_den,
    output logic                            o_done,
    output logic [adt_pkg::QUO_BITS-1:0]    o_quo
);
    import adt_pkg::*;

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic                 r_busy;
    logic [CW-1:0]        r_cnt;
    logic [NORM_BITS-1:0] r_rem;
    logic [NORM_BITS-1:0] r_den;
    logic [QUO_BITS-1:0]  r_q;
    logic [NORM_BITS:0]   w_rem2;
    logic                 w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_go) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(FRAC_BITS);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_den <= i_den;
            if (i_num >= i_den) begin
                r_rem <= i_num - i_den;
                r_q   <= QUO_BITS'(1);
            end else begin
                r_rem <= i_num;
                r_q   <= '0;
            end
        end else if (r_busy && (r_cnt != '0)) begin
            if (w_ge) begin
                r_rem <= NORM_BITS'(w_rem2 - {1'b0, r_den});
            end else begin
                r_rem <= w_rem2[NORM_BITS-1:0];
            end
            r_q <= {r_q[QUO_BITS-2:0], w_ge};
        end
    end

endmodule

// ===== rtl/adt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_ctrl: iteration sequencer
// Steps the datapath through setup, each iteration and the result.
// ----------------------------------------------------------------------------
module adt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  adt_pkg::t_dp_sts  i_sts,
    output adt_pkg::t_dp_cmd  o_cmd
);
    import adt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (start) n_state = ST_C_SR;
            ST_C_SR:     n_state = ST_C_SR_W;
            ST_C_SR_W:   if (i_sts.mul_done) n_state = ST_C_SI;
            ST_C_SI:     n_state = ST_C_SI_W;
            ST_C_SI_W:   if (i_sts.mul_done) n_state = ST_C_NC;
            ST_C_NC:     n_state = ST_I_LIM;
            ST_I_LIM:    n_state = i_sts.lim ? ST_DONE : ST_I_SR;
            ST_I_SR:     n_state = ST_I_SR_W;
            ST_I_SR_W:   if (i_sts.mul_done) n_state = ST_I_SI;
            ST_I_SI:     n_state = ST_I_SI_W;
            ST_I_SI_W:   if (i_sts.mul_done) n_state = ST_I_TEST;
            ST_I_TEST: begin
                if (i_sts.esc) n_state = ST_DONE;
                else if (i_sts.nzero) n_state = ST_I_ZERO;
                else n_state = ST_I_ARAI;
            end
            ST_I_ZERO:   n_state = ST_I_COMMIT;
            ST_I_ARAI:   n_state = ST_I_ARAI_W;
            ST_I_ARAI_W: if (i_sts.mul_done) n_state = ST_I_DIV;
            ST_I_DIV:    n_state = ST_I_DIV_W;
            ST_I_DIV_W:  if (i_sts.div_done) n_state = ST_I_LAM;
            ST_I_LAM:    n_state = ST_I_LAM_W;
            ST_I_LAM_W:  if (i_sts.mul_done) n_state = ST_I_SUR;
            ST_I_SUR:    n_state = ST_I_SUR_W;
            ST_I_SUR_W:  if (i_sts.mul_done) n_state = ST_I_SUI;
            ST_I_SUI:    n_state = ST_I_SUI_W;
            ST_I_SUI_W:  if (i_sts.mul_done) n_state = ST_I_COMMIT;
            ST_I_COMMIT: n_state = i_sts.ovf ? ST_DONE : ST_I_LIM;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_SR;
        busy          = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE:     o_cmd.load = start;
            ST_C_SR:     o_cmd.mul_go = 1'b1;
            ST_C_SR_W:   o_cmd.mul_sel = MS_SR;
            ST_C_SI: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_SI;
            end
            ST_C_SI_W:   o_cmd.mul_sel = MS_SI;
            ST_C_NC:     o_cmd.latch_nc = 1'b1;
            ST_I_SR:     o_cmd.mul_go = 1'b1;
            ST_I_SR_W:   o_cmd.mul_sel = MS_SR;
            ST_I_SI: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_SI;
            end
            ST_I_SI_W:   o_cmd.mul_sel = MS_SI;
            ST_I_ZERO:   o_cmd.set_zero = 1'b1;
            ST_I_ARAI: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_ARAI;
            end
            ST_I_ARAI_W: o_cmd.mul_sel = MS_ARAI;
            ST_I_DIV:    o_cmd.div_go = 1'b1;
            ST_I_LAM: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_LAM;
            end
            ST_I_LAM_W:  o_cmd.mul_sel = MS_LAM;
            ST_I_SUR: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_SUR;
            end
            ST_I_SUR_W:  o_cmd.mul_sel = MS_SUR;
            ST_I_SUI: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_SUI;
            end
            ST_I_SUI_W:  o_cmd.mul_sel = MS_SUI;
            ST_I_COMMIT: o_cmd.commit = 1'b1;
            ST_DONE:     o_cmd.finish = 1'b1;
            default:     o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/adt_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adt_dp: iteration datapath
// Holds the point, the iterate and the settings, and computes norms, the
// unit factor, the scale factor and the next iterate.
// ----------------------------------------------------------------------------
module adt_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  adt_pkg::t_dp_cmd                       i_cmd,
    output adt_pkg::t_dp_sts                       o_sts,
    input  logic                                   i_cfg_we,
    input  logic [adt_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [adt_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata,
    input  logic signed [adt_pkg::WORD_BITS-1:0]   i_c_re,
    input  logic signed [adt_pkg::WORD_BITS-1:0]   i_c_im,
    output logic                                   o_valid,
    output logic [adt_pkg::CNT_BITS-1:0]           o_iter_count,
    output logic                                   o_bounded
);
    import adt_pkg::*;

    logic signed [WORD_BITS-1:0] r_lambda;
    logic [CNT_BITS-1:0]         r_max_iter;
    logic signed [WORD_BITS-1:0] r_cr, r_ci, r_xr, r_xi;
    logic [CNT_BITS-1:0]         r_cnt;
    logic [NORM_BITS-1:0]        r_sr, r_si, r_nc, r_p2;
    logic                        r_big;
    logic                        r_ur_neg, r_ui_neg;
    logic signed [S_BITS-1:0]    r_s;
    logic signed [NEW_BITS-1:0]  r_new_re, r_new_im;
    logic                        r_valid;
    logic [CNT_BITS-1:0]         r_iter;
    logic                        r_bounded;

    logic [WORD_BITS-1:0]        w_ar, w_ai, w_lam_mag;
    logic [NORM_BITS-1:0]        w_n, w_dm;
    logic signed [NTM_BITS-1:0]  w_ntm1;
    logic [NTM_BITS-1:0]         w_ntm1_mag;
    logic [MA_BITS-1:0]          w_s_mag;
    logic [MA_BITS-1:0]          w_ma;
    logic [MB_BITS-1:0]          w_mb;
    logic                        w_mul_done;
    logic [PROD_BITS-1:0]        w_prod;
    logic [NEW_BITS-1:0]         w_pq;
    logic                        w_pneg;
    logic signed [NEW_BITS-1:0]  w_term;
    logic                        w_dre, w_dim;
    logic [QUO_BITS-1:0]         w_qr, w_qi;
    logic                        w_lim;
    logic [NEW_BITS-WORD_BITS:0] w_top_re, w_top_im;

    assign w_ar      = r_xr[WORD_BITS-1] ? WORD_BITS'(-r_xr) : WORD_BITS'(r_xr);
    assign w_ai      = r_xi[WORD_BITS-1] ? WORD_BITS'(-r_xi) : WORD_BITS'(r_xi);
    assign w_lam_mag = r_lambda[WORD_BITS-1] ? WORD_BITS'(-r_lambda) : WORD_BITS'(r_lambda);
    assign w_n       = r_sr + r_si;
    assign w_dm      = (r_sr >= r_si) ? (r_sr - r_si) : (r_si - r_sr);
    assign w_ntm1    = $signed({1'b0, w_n[NORM_BITS-1:FRAC_BITS]})
                       - $signed(NTM_BITS'(64'd1 << FRAC_BITS));
    assign w_ntm1_mag = w_ntm1[NTM_BITS-1] ? NTM_BITS'(-w_ntm1) : NTM_BITS'(w_ntm1);
    assign w_s_mag   = r_s[S_BITS-1] ? MA_BITS'(-r_s) : MA_BITS'(r_s);
    assign w_lim     = (r_cnt >= r_max_iter);

    always_comb begin
        case (i_cmd.mul_sel)
            MS_SR: begin
                w_ma   = MA_BITS'(w_ar);
                w_mb   = MB_BITS'(w_ar);
                w_pneg = 1'b0;
            end
            MS_SI: begin
                w_ma   = MA_BITS'(w_ai);
                w_mb   = MB_BITS'(w_ai);
                w_pneg = 1'b0;
            end
            MS_ARAI: begin
                w_ma   = MA_BITS'(w_ar);
                w_mb   = MB_BITS'(w_ai);
                w_pneg = 1'b0;
            end
            MS_LAM: begin
                w_ma   = MA_BITS'(w_lam_mag);
                w_mb   = MB_BITS'(w_ntm1_mag);
                w_pneg = r_lambda[WORD_BITS-1] ^ w_ntm1[NTM_BITS-1];
            end
            MS_SUR: begin
                w_ma   = w_s_mag;
                w_mb   = MB_BITS'(w_qr);
                w_pneg = r_s[S_BITS-1] ^ r_ur_neg;
            end
            MS_SUI: begin
                w_ma   = w_s_mag;
                w_mb   = MB_BITS'(w_qi);
                w_pneg = r_s[S_BITS-1] ^ r_ui_neg;
            end
            default: begin
                w_ma   = '0;
                w_mb   = '0;
                w_pneg = 1'b0;
            end
        endcase
    end

    adt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.mul_go),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    adt_div u_div_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (w_dm),
        .i_den   (w_n),
        .o_done  (w_dre),
        .o_quo   (w_qr)
    );

    adt_div u_div_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (i_cmd.div_go),
        .i_num   (r_p2),
        .i_den   (w_n),
        .o_done  (w_dim),
        .o_quo   (w_qi)
    );

    assign w_pq   = w_prod[FRAC_BITS +: NEW_BITS];
    assign w_term = w_pneg ? -$signed(w_pq) : $signed(w_pq);

    assign w_top_re = r_new_re[NEW_BITS-1:WORD_BITS-1];
    assign w_top_im = r_new_im[NEW_BITS-1:WORD_BITS-1];

    assign o_sts.mul_done = w_mul_done;
    assign o_sts.div_done = w_dre & w_dim;
    assign o_sts.lim      = w_lim;
    assign o_sts.esc      = r_big ? ((w_n >> 1) >= r_nc) : (w_n >= NORM_TWENTY);
    assign o_sts.nzero    = (w_n == '0);
    assign o_sts.ovf      = !((&w_top_re) || (~|w_top_re)) || !((&w_top_im) || (~|w_top_im));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lambda   <= LAMBDA_RESET;
            r_max_iter <= MAX_ITER_RESET;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAMBDA:   r_lambda   <= $signed(i_cfg_wdata[WORD_BITS-1:0]);
                    CFG_MAX_ITER: r_max_iter <= i_cfg_wdata[CNT_BITS-1:0];
                    default:      r_lambda   <= r_lambda;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cr  <= i_c_re;
            r_ci  <= i_c_im;
            r_xr  <= i_c_re;
            r_xi  <= i_c_im;
            r_cnt <= '0;
        end
        if (i_cmd.latch_nc) begin
            r_nc  <= w_n;
            r_big <= (w_n > NORM_TEN);
        end
        if (i_cmd.div_go) begin
            r_ur_neg <= (r_sr < r_si);
            r_ui_neg <= r_xr[WORD_BITS-1] ^ r_xi[WORD_BITS-1];
        end
        if (w_mul_done) begin
            case (i_cmd.mul_sel)
                MS_SR:   r_sr <= w_prod[NORM_BITS-1:0];
                MS_SI:   r_si <= w_prod[NORM_BITS-1:0];
                MS_ARAI: r_p2 <= {w_prod[NORM_BITS-2:0], 1'b0};
                MS_LAM:  r_s  <= ONE_S + w_term;
                MS_SUR:  r_new_re <= w_term + NEW_BITS'(r_cr);
                MS_SUI:  r_new_im <= w_term + NEW_BITS'(r_ci);
                default: r_sr <= r_sr;
            endcase
        end
        if (i_cmd.set_zero) begin
            r_new_re <= NEW_BITS'(r_cr) + ONE_S - NEW_BITS'(r_lambda);
            r_new_im <= NEW_BITS'(r_ci);
        end
        if (i_cmd.commit) begin
            r_xr  <= r_new_re[WORD_BITS-1:0];
            r_xi  <= r_new_im[WORD_BITS-1:0];
            r_cnt <= r_cnt + CNT_BITS'(1);
        end
        if (i_cmd.finish) begin
            r_bounded <= w_lim;
            r_iter    <= w_lim ? r_max_iter : r_cnt;
        end
    end

    assign o_valid      = r_valid;
    assign o_iter_count = r_iter;
    assign o_bounded    = r_bounded;

endmodule

// ===== rtl/angle_doubling_escape_time_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_doubling_escape_time_top: escape-time iteration of the doubling map
// Iterates one point of the parameter plane and reports its escape count.
// ----------------------------------------------------------------------------
// A point is taken when start is high while busy is low, and its word
// appears on o_iter_count and o_bounded with o_valid high for exactly one
// cycle; it must be captured then. Each iteration uses one shared sequential
// multiplier six times (twice when the iterate is zero) and two bit-serial
// dividers, run side by side, that form the unit factor.
module angle_doubling_escape_time_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic [adt_pkg::CFG_IDX_BITS-1:0]       i_cfg_idx,
    input  logic [adt_pkg::CFG_DATA_BITS-1:0]      i_cfg_wdata,
    input  logic signed [adt_pkg::WORD_BITS-1:0]   i_c_re,
    input  logic signed [adt_pkg::WORD_BITS-1:0]   i_c_im,
    output logic                                   o_valid,
    output logic [adt_pkg::CNT_BITS-1:0]           o_iter_count,
    output logic                                   o_bounded
);
    import adt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    adt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    adt_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_c_re       (i_c_re),
        .i_c_im       (i_c_im),
        .o_valid      (o_valid),
        .o_iter_count (o_iter_count),
        .o_bounded    (o_bounded)
    );

endmodule

// ===== dv/angle_doubling_escape_time_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_doubling_escape_time_top_tb: self-checking bench for the escape engine
// A queue-fed driver issues points of the parameter plane, and a monitor
// checks every result word against a fixed-point predictor of the iteration.
// Both the map parameter and the iteration limit are swept across phases.
// ----------------------------------------------------------------------------
module angle_doubling_escape_time_top_tb;

    import adt_pkg::*;

    localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
    localparam int     ITER_CAP   = 40;
    localparam int     WDOG_LIMIT = 200000;

    typedef struct {
        logic signed [WORD_BITS-1:0] c_re;
        logic signed [WORD_BITS-1:0] c_im;
        logic [CNT_BITS-1:0]         count;
        logic                        bounded;
    } t_point;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic                          i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]       i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0]      i_cfg_wdata = '0;
    logic signed [WORD_BITS-1:0]   i_c_re = '0;
    logic signed [WORD_BITS-1:0]   i_c_im = '0;
    logic                          o_valid;
    logic [CNT_BITS-1:0]           o_iter_count;
    logic                          o_bounded;

    t_point pending_points[$];
    t_point expected_words[$];
    longint lambda_q = ONE_Q;
    int     iter_limit = 500;
    int     idle_pct = 36;
    int     errors = 0;
    int     quiet_cycles = 0;

    angle_doubling_escape_time_top i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic longint scale_mul(input longint a, input longint b);
        logic [127:0] prod;
        longint unsigned ua, ub;
        ua = (a < 0) ? longint'(-a) : a;
        ub = (b < 0) ? longint'(-b) : b;
        prod = ({64'd0, ua} * {64'd0, ub}) >> FRAC_BITS;
        if (prod > (128'd1 << 62))
            prod = 128'd1 << 62;
        return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic longint unsigned unit_div(input longint unsigned num,
                                                 input longint unsigned den);
        logic [127:0] q;
        q = ({64'd0, num} << FRAC_BITS) / {64'd0, den};
        return q[63:0];
    endfunction

    // Runs at most lim steps; the bounded flag means lim was reached.
    function automatic void predict_escape(input logic signed [WORD_BITS-1:0] cr_w,
                                           input logic signed [WORD_BITS-1:0] ci_w,
                                           input int lim, output int cnt,
                                           output bit bnd);
        longint cr, ci, xr, xi, nr, ni, ur, ui, nt, s;
        longint unsigned nc, n, ar, ai, sr, si, dm;
        bit big;
        cr = cr_w;
        ci = ci_w;
        nc = longint'(cr * cr) + longint'(ci * ci);
        big = nc > (longint'(10) << (2 * FRAC_BITS));
        xr = cr;
        xi = ci;
        cnt = 0;
        while (cnt < lim) begin
            ar = (xr < 0) ? -xr : xr;
            ai = (xi < 0) ? -xi : xi;
            sr = ar * ar;
            si = ai * ai;
            n = sr + si;
            if (big ? ((n >> 1) >= nc) : (n >= (longint'(20) << (2 * FRAC_BITS))))
                break;
            if (n == 0) begin
                nr = cr + ONE_Q - lambda_q;
                ni = ci;
            end else begin
                dm = (sr >= si) ? sr - si : si - sr;
                ur = unit_div(dm, n);
                ui = unit_div(2 * ar * ai, n);
                nt = n >> FRAC_BITS;
                s = ONE_Q + scale_mul(lambda_q, nt - ONE_Q);
                if (sr < si)
                    ur = -ur;
                if ((xr < 0) != (xi < 0))
                    ui = -ui;
                nr = scale_mul(s, ur) + cr;
                ni = scale_mul(s, ui) + ci;
            end
            cnt++;
            if (nr > 64'sh7FFF_FFFF || nr < -64'sh8000_0000 ||
                ni > 64'sh7FFF_FFFF || ni < -64'sh8000_0000)
                break;
            xr = nr;
            xi = ni;
        end
        bnd = (cnt >= lim);
        if (bnd)
            cnt = lim;
    endfunction

    // Queues a point; with a cap, points slower than the cap are dropped.
    function automatic bit queue_point(input logic signed [WORD_BITS-1:0] cr,
                                       input logic signed [WORD_BITS-1:0] ci,
                                       input bit capped);
        t_point p;
        int lim, cnt;
        bit bnd;
        lim = (capped && iter_limit > ITER_CAP) ? ITER_CAP : iter_limit;
        predict_escape(cr, ci, lim, cnt, bnd);
        if (bnd && lim < iter_limit)
            return 1'b0;
        p.c_re = cr;
        p.c_im = ci;
        p.count = cnt[CNT_BITS-1:0];
        p.bounded = bnd;
        pending_points.push_back(p);
        return 1'b1;
    endfunction

    function automatic logic signed [WORD_BITS-1:0] random_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return '0;
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : -32'sh8000_0000;
            3, 4: return $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
            default: return $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_LAMBDA)
            lambda_q = longint'($signed(data));
        else
            iter_limit = data[CNT_BITS-1:0];
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || expected_words.size() != 0 || start || busy)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_words.push_back(pending_points.pop_front());
        end
        if (i_rst_n && (!start || !busy) && pending_points.size() != 0 &&
            ($urandom_range(99) >= idle_pct || (start && !busy && 0))) begin
            start <= 1'b1;
            i_c_re <= pending_points[0].c_re;
            i_c_im <= pending_points[0].c_im;
        end else if (!start || !busy) begin
            start <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_point e;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word count=%0d bounded=%0b", $time,
                         o_iter_count, o_bounded);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (o_iter_count !== e.count) begin
                    $display("%0t: iter_count expected %0d actual %0d (c=%h,%h)", $time,
                             e.count, o_iter_count, e.c_re, e.c_im);
                    errors++;
                end
                if (o_bounded !== e.bounded) begin
                    $display("%0t: bounded expected %0b actual %0b (c=%h,%h)", $time,
                             e.bounded, o_bounded, e.c_re, e.c_im);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] lambdas[10];
        int          limits[10];
        int          added;
        lambdas = '{32'h0100_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                    32'h0080_0000, 32'hFF00_0000, 32'h0100_0000, 32'h0180_0000,
                    32'h0100_0000, 32'h0040_0000};
        limits = '{20, 8, 1, 40, 65535, 0, 64, 12, 30, 16};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        void'(queue_point('0, '0, 1'b0));
        void'(queue_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0));
        void'(queue_point(-32'sh8000_0000, -32'sh8000_0000, 1'b0));
        void'(queue_point(32'sh7FFF_FFFF, -32'sh8000_0000, 1'b0));
        void'(queue_point(-32'sh8000_0000, '0, 1'b0));
        void'(queue_point('0, 32'sh7FFF_FFFF, 1'b0));
        void'(queue_point(-32'sh0200_0000, '0, 1'b0));
        void'(queue_point(32'sh0100_0000, '0, 1'b0));
        void'(queue_point(32'sh0040_0000, 32'sh0080_0000, 1'b0));
        void'(queue_point(32'sh0400_0000, 32'sh0300_0000, 1'b0));
        void'(queue_point(32'sh0000_0001, -32'sh0000_0001, 1'b0));
        wait_drained();
        write_reg(CFG_LAMBDA, 32'h0000_0000);
        void'(queue_point('0, '0, 1'b0));
        void'(queue_point(32'sh0100_0000, 32'sh0100_0000, 1'b0));
        void'(queue_point(-32'sh0080_0000, 32'sh0020_0000, 1'b0));
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            idle_pct = (p < 3) ? 36 : (p < 6) ? 86 : 0;
            write_reg(CFG_LAMBDA, lambdas[p]);
            write_reg(CFG_MAX_ITER, limits[p]);
            added = 0;
            while (added < 60) begin
                if (queue_point(random_coord(), random_coord(), 1'b1))
                    added++;
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== angle_doubling_escape_time_top.f =====
rtl/adt_pkg.sv
rtl/adt_mul.sv
rtl/adt_div.sv
rtl/adt_ctrl.sv
rtl/adt_dp.sv
rtl/angle_doubling_escape_time_top.sv
dv/angle_doubling_escape_time_top_tb.sv
